### hdl/uhtc_pkg.sv
`default_nettype none

package uhtc_pkg;

	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned RATE_W    = 20;
	localparam int unsigned TICKS_W   = 2 * SAMPLE_W;
	localparam int unsigned CENTI_W   = 7;
	localparam int unsigned FRAC_BITS = 7;
	localparam int unsigned CNT_W     = 7;
	localparam int unsigned PAD_W     = TICKS_W - FRAC_BITS;

	localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(1000);
	localparam logic [CENTI_W-1:0] CENTI      = CENTI_W'(100);
	localparam logic [CNT_W-1:0]   DIV_STEPS  = CNT_W'(TICKS_W);
	localparam logic [CNT_W-1:0]   FRAC_STEPS = CNT_W'(FRAC_BITS);

	typedef logic [2:0] state_t;

endpackage

`default_nettype wire

### hdl/uptime_hundredths_from_tick_counter_unit.sv
`default_nettype none

// Uptime in hundredths of a second from samples of a free-running 32-bit tick counter.
// Slave stream: one beat carries a counter sample. A sample below the previous one
// counts as a counter rollover; rollovers and sample form a 64-bit tick count.
// Master stream: one beat per input beat with the uptime in hundredths, mod 2^32.
// cfg_we/cfg_wdata write the tick rate in Hz; write it only while the block is idle.
// A rate of zero is used as one.
// One shared 20-bit restoring subtract/compare unit does all division: 64 steps
// for whole seconds, then 7 steps for the fractional hundredths, with a multiply
// state between and a final state that loads the output register.
// The block takes no new sample until it has finished the last one. s_axis_tready
// is high in idle, also while a finished beat waits at the output; a new result
// that finds the output register still full holds in its last state until
// m_axis_tready frees it.
// Reset: rate returns to 1000 Hz, last sample and rollover count clear to zero,
// the output register empties.
module uptime_hundredths_from_tick_counter_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [31:0] now_ticks
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [31:0] uptime_hundredths
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata      // tick_rate_hz
);

	localparam uhtc_pkg::state_t ST_IDLE = 3'd0;
	localparam uhtc_pkg::state_t ST_DIV  = 3'd1;
	localparam uhtc_pkg::state_t ST_MUL  = 3'd2;
	localparam uhtc_pkg::state_t ST_FRAC = 3'd3;
	localparam uhtc_pkg::state_t ST_FIN  = 3'd4;

	uhtc_pkg::state_t                       state_q;
	logic [uhtc_pkg::RATE_W-1:0]            rate_q;
	logic [uhtc_pkg::RATE_W-1:0]            div_q;
	logic [uhtc_pkg::SAMPLE_W-1:0]          last_q;
	logic [uhtc_pkg::SAMPLE_W-1:0]          wrap_q;
	logic [uhtc_pkg::RATE_W-1:0]            rem_q;
	logic [uhtc_pkg::TICKS_W-1:0]           sh_q;
	logic [uhtc_pkg::CNT_W-1:0]             cnt_q;
	logic [uhtc_pkg::SAMPLE_W-1:0]          acc_q;
	logic [uhtc_pkg::SAMPLE_W-1:0]          out_q;
	logic                                   out_vld_q;

	logic                                   in_fire;
	logic [uhtc_pkg::SAMPLE_W-1:0]          wrap_nxt;
	logic [uhtc_pkg::RATE_W:0]              trial;
	logic [uhtc_pkg::RATE_W+1:0]            diff;
	logic                                   ge;
	logic [uhtc_pkg::RATE_W-1:0]            rem_nxt;
	logic [uhtc_pkg::SAMPLE_W-1:0]          qprod;
	logic [uhtc_pkg::RATE_W+uhtc_pkg::CENTI_W-1:0]   rprod;
	logic                                   out_free;
	logic                                   out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;
	assign out_free      = !out_vld_q || m_axis_tready;
	assign out_load      = (state_q == ST_FIN) && out_free;

	assign wrap_nxt = (s_axis_tdata < last_q) ? wrap_q + uhtc_pkg::SAMPLE_W'(1) : wrap_q;

	// shared restoring divide step
	assign trial   = {rem_q, sh_q[uhtc_pkg::TICKS_W-1]};
	assign diff    = {1'b0, trial} - {2'b00, div_q};
	assign ge      = !diff[uhtc_pkg::RATE_W+1];
	assign rem_nxt = ge ? diff[uhtc_pkg::RATE_W-1:0] : trial[uhtc_pkg::RATE_W-1:0];

	assign qprod = sh_q[uhtc_pkg::SAMPLE_W-1:0] * uhtc_pkg::SAMPLE_W'(uhtc_pkg::CENTI);
	assign rprod = {{uhtc_pkg::CENTI_W{1'b0}}, rem_q} *
		{{uhtc_pkg::RATE_W{1'b0}}, uhtc_pkg::CENTI};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rate_q    <= uhtc_pkg::RATE_RESET;
			last_q    <= '0;
			wrap_q    <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				rate_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_q  <= s_axis_tdata;
						wrap_q  <= wrap_nxt;
						cnt_q   <= uhtc_pkg::DIV_STEPS;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - uhtc_pkg::CNT_W'(1);
					if (cnt_q == uhtc_pkg::CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					cnt_q   <= uhtc_pkg::FRAC_STEPS;
					state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					cnt_q <= cnt_q - uhtc_pkg::CNT_W'(1);
					if (cnt_q == uhtc_pkg::CNT_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register can take the beat
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					div_q <= (rate_q == '0) ? uhtc_pkg::RATE_W'(1) : rate_q;
					rem_q <= '0;
					sh_q  <= {wrap_nxt, s_axis_tdata};
				end
			end
			ST_DIV, ST_FRAC: begin
				rem_q <= rem_nxt;
				sh_q  <= {sh_q[uhtc_pkg::TICKS_W-2:0], ge};
			end
			ST_MUL: begin
				// whole seconds times 100, then seed the fraction divide with remainder*100
				acc_q <= qprod;
				rem_q <= rprod[uhtc_pkg::RATE_W+uhtc_pkg::CENTI_W-1:uhtc_pkg::FRAC_BITS];
				sh_q  <= {rprod[uhtc_pkg::FRAC_BITS-1:0], {uhtc_pkg::PAD_W{1'b0}}};
			end
			ST_FIN: begin
				if (out_free) begin
					out_q <= acc_q + uhtc_pkg::SAMPLE_W'(sh_q[uhtc_pkg::FRAC_BITS-1:0]);
				end
			end
			default: begin
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_DIV) && (cnt_q == uhtc_pkg::DIV_STEPS))
		else $error("accepted beat did not start the whole-seconds divide");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_FRAC) |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_FRAC) |-> (div_q != '0))
		else $error("divisor is zero during divide");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_FRAC) |-> (cnt_q != '0))
		else $error("step counter empty while dividing");
`endif

endmodule

`default_nettype wire
